// ===== rtl/rie_pkg.sv =====
package rie_pkg;

    localparam int OP_W    = 5;
    localparam int REG_W   = 5;
    localparam int IMM_W   = 32;
    localparam int WORD_W  = 32;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'h6F;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MUL  = 7'b0000001;

    typedef enum logic [OP_W-1:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_AND, OP_OR, OP_XOR,
        OP_SLL, OP_SRL, OP_SRA, OP_SLT,
        OP_ADDI, OP_ANDI, OP_ORI, OP_LB, OP_LH, OP_LW, OP_LD, OP_JALR,
        OP_SB, OP_SH, OP_SW, OP_SD,
        OP_BEQ, OP_BNE, OP_BGE, OP_BLT,
        OP_LUI, OP_AUIPC, OP_JAL, OP_UNKNOWN
    } op_t;

    typedef enum logic [2:0] {
        FMT_R, FMT_I, FMT_S, FMT_SB, FMT_U, FMT_UJ, FMT_NONE
    } fmt_t;

    typedef struct packed {
        fmt_t       fmt;
        logic [6:0] opc;
        logic [2:0] f3;
        logic [6:0] f7;
    } enc_entry_t;

    function automatic enc_entry_t enc_lookup(input op_t op);
        enc_entry_t e;
        e = '{fmt: FMT_NONE, opc: 7'd0, f3: 3'd0, f7: F7_BASE};
        case (op)
            OP_ADD:   e = '{FMT_R,  OPC_OP,     3'd0, F7_BASE};
            OP_SUB:   e = '{FMT_R,  OPC_OP,     3'd0, F7_ALT};
            OP_MUL:   e = '{FMT_R,  OPC_OP,     3'd0, F7_MUL};
            OP_DIV:   e = '{FMT_R,  OPC_OP,     3'd4, F7_MUL};
            OP_REM:   e = '{FMT_R,  OPC_OP,     3'd6, F7_MUL};
            OP_AND:   e = '{FMT_R,  OPC_OP,     3'd7, F7_BASE};
            OP_OR:    e = '{FMT_R,  OPC_OP,     3'd6, F7_BASE};
            OP_XOR:   e = '{FMT_R,  OPC_OP,     3'd4, F7_BASE};
            OP_SLL:   e = '{FMT_R,  OPC_OP,     3'd1, F7_BASE};
            OP_SRL:   e = '{FMT_R,  OPC_OP,     3'd5, F7_BASE};
            OP_SRA:   e = '{FMT_R,  OPC_OP,     3'd5, F7_ALT};
            OP_SLT:   e = '{FMT_R,  OPC_OP,     3'd2, F7_BASE};
            OP_ADDI:  e = '{FMT_I,  OPC_OPIMM,  3'd0, F7_BASE};
            OP_ANDI:  e = '{FMT_I,  OPC_OPIMM,  3'd7, F7_BASE};
            OP_ORI:   e = '{FMT_I,  OPC_OPIMM,  3'd6, F7_BASE};
            OP_LB:    e = '{FMT_I,  OPC_LOAD,   3'd0, F7_BASE};
            OP_LH:    e = '{FMT_I,  OPC_LOAD,   3'd1, F7_BASE};
            OP_LW:    e = '{FMT_I,  OPC_LOAD,   3'd2, F7_BASE};
            OP_LD:    e = '{FMT_I,  OPC_LOAD,   3'd3, F7_BASE};
            OP_JALR:  e = '{FMT_I,  OPC_JALR,   3'd0, F7_BASE};
            OP_SB:    e = '{FMT_S,  OPC_STORE,  3'd0, F7_BASE};
            OP_SH:    e = '{FMT_S,  OPC_STORE,  3'd1, F7_BASE};
            OP_SW:    e = '{FMT_S,  OPC_STORE,  3'd2, F7_BASE};
            OP_SD:    e = '{FMT_S,  OPC_STORE,  3'd3, F7_BASE};
            OP_BEQ:   e = '{FMT_SB, OPC_BRANCH, 3'd0, F7_BASE};
            OP_BNE:   e = '{FMT_SB, OPC_BRANCH, 3'd1, F7_BASE};
            OP_BGE:   e = '{FMT_SB, OPC_BRANCH, 3'd5, F7_BASE};
            OP_BLT:   e = '{FMT_SB, OPC_BRANCH, 3'd4, F7_BASE};
            OP_LUI:   e = '{FMT_U,  OPC_LUI,    3'd0, F7_BASE};
            OP_AUIPC: e = '{FMT_U,  OPC_AUIPC,  3'd0, F7_BASE};
            OP_JAL:   e = '{FMT_UJ, OPC_JAL,    3'd0, F7_BASE};
            default:  e = '{FMT_NONE, 7'd0,     3'd0, F7_BASE};
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/rie_encode.sv =====
module rie_encode (
    input  rie_pkg::op_t                 op,
    input  logic [rie_pkg::REG_W-1:0]    rd,
    input  logic [rie_pkg::REG_W-1:0]    rs1,
    input  logic [rie_pkg::REG_W-1:0]    rs2,
    input  logic [rie_pkg::IMM_W-1:0]    imm,
    output logic [rie_pkg::WORD_W-1:0]   word,
    output logic                         word_ok
);
    import rie_pkg::*;

    enc_entry_t e;

    assign e = enc_lookup(op);

    always_comb begin
        word    = '0;
        word_ok = 1'b1;
        case (e.fmt)
            FMT_R: begin
                word = {e.f7, rs2, rs1, e.f3, rd, e.opc};
            end
            FMT_I: begin
                word = {imm[11:0], rs1, e.f3, rd, e.opc};
            end
            FMT_S: begin
                word = {imm[11:5], rs2, rs1, e.f3, imm[4:0], e.opc};
            end
            FMT_SB: begin
                // Bit 0 of a branch offset is implied and never encoded.
                word = {imm[12], imm[10:5], rs2, rs1, e.f3, imm[4:1], imm[11], e.opc};
            end
            FMT_U: begin
                word = {imm[19:0], rd, e.opc};
            end
            FMT_UJ: begin
                word = {imm[20], imm[10:1], imm[11], imm[19:12], rd, e.opc};
            end
            default: begin
                word    = '0;
                word_ok = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/riscv_instruction_encoder.sv =====
// RISC-V instruction encoder.
// Each request on the s_axis channel carries a mnemonic code, the register
// numbers rd, rs1 and rs2 and a signed immediate (branch and jump offsets are
// byte offsets). The m_axis channel returns one result for every request: the
// 32-bit machine word in m_axis_tdata and a flag in m_axis_tuser that is high
// when the mnemonic code is known; an unknown code gives a zero word.
// The request is captured in an input register, encoded by table lookup and
// bit packing, and held in the output register, from which it is offered on
// m_axis. One request can be accepted per cycle while the receiver takes
// results. When the receiver holds m_axis_tready low, the output register
// keeps its result, the input register fills, and s_axis_tready falls until
// the result is taken; nothing is dropped or repeated.
// Reset empties both registers and holds s_axis_tready low; s_axis_tready is
// high again as soon as aresetn is released.
module riscv_instruction_encoder (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // operation[4:0], dest_reg[9:5], src1_reg[14:10], src2_reg[19:15],
    // immediate[51:20], zero[55:52]
    input  logic [rie_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // machine_word[31:0]
    output logic [rie_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // valid_res[0]
    output logic                              m_axis_tuser
);
    import rie_pkg::*;

    logic                 in_valid_reg;
    op_t                  op_reg;
    logic [REG_W-1:0]     rd_reg;
    logic [REG_W-1:0]     rs1_reg;
    logic [REG_W-1:0]     rs2_reg;
    logic [IMM_W-1:0]     imm_reg;

    logic                 out_valid_reg;
    logic [WORD_W-1:0]    word_reg;
    logic                 word_ok_reg;

    logic [WORD_W-1:0]    word_next;
    logic                 word_ok_next;
    logic                 out_load;
    logic                 in_load;

    // The output register takes a new result whenever it is empty or being read.
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign in_load       = !in_valid_reg || out_load;
    assign s_axis_tready = aresetn && in_load;

    rie_encode u_encode (
        .op      (op_reg),
        .rd      (rd_reg),
        .rs1     (rs1_reg),
        .rs2     (rs2_reg),
        .imm     (imm_reg),
        .word    (word_next),
        .word_ok (word_ok_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load && s_axis_tvalid) begin
            op_reg  <= op_t'(s_axis_tdata[4:0]);
            rd_reg  <= s_axis_tdata[9:5];
            rs1_reg <= s_axis_tdata[14:10];
            rs2_reg <= s_axis_tdata[19:15];
            imm_reg <= s_axis_tdata[51:20];
        end
        if (out_load && in_valid_reg) begin
            word_reg    <= word_next;
            word_ok_reg <= word_ok_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = word_reg;
    assign m_axis_tuser  = word_ok_reg;

`ifndef NO_ASSERTIONS
    a_invalid_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("unknown mnemonic gave a non-zero word");

    a_known_word_opcode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[1:0] == 2'b11)
        else $error("encoded word lacks the 32-bit opcode marker");

    a_unknown_flagged: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_load && op_reg == OP_UNKNOWN |=> m_axis_tvalid && !m_axis_tuser)
        else $error("unknown mnemonic was not flagged");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("request refused while a register was free");
`endif

endmodule
